FILE: hdl/bbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    // Default sizes
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_LENGTH_DEF  = 4096;

    // Reported position saturates at this value
    localparam logic [11:0] POS_MAX = 12'hFFF;

    // Bracket characters
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C; // <
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E; // >

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_ANGLE  = 2'd3
    } bbc_kind_t;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_UNCLOSED = 2'd2,
        ST_OVERFLOW = 2'd3
    } bbc_status_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_string;
    } bbc_in_t;

    typedef struct packed {
        bbc_status_t status;
        logic [11:0] error_position;
    } bbc_out_t;

    typedef struct packed {
        logic      is_open;
        logic      is_close;
        bbc_kind_t kind;
    } bbc_class_t;

    // Sort a character into opener, closer or other, with its bracket kind
    function automatic bbc_class_t bbc_classify(input logic [7:0] ch);
        bbc_class_t c;
        c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        unique case (ch)
            CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
            CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
            CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
            CH_OPEN_ANGLE:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
            CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
            CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
            CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
            CH_CLOSE_ANGLE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
            default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bracket_balance_checker_unit.sv
// Channel  | Handshake               | Item                          | Role
// ---------+-------------------------+-------------------------------+---------------------
// sym      | sym_valid / sym_ready   | bbc_in_t  (symbol, eos)       | one character
// res      | res_valid / res_ready   | bbc_out_t (status, position)  | verdict per string
//
// One character is taken every cycle while sym_ready is high; the verdict of a string
// appears in the cycle after its end_of_string item is taken, held in an output register.
// The stack lives in a one-port-write, one-port-read RAM; the top entry is kept
// in a register, and after a pop the new top arrives from the RAM read register.
// Reset clears count, index and error state at once; the RAM needs no clearing.
// sym_ready drops only while a verdict waits and res_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker_unit
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     sym_valid,
    output logic          sym_ready,
    input  wire bbc_in_t  sym_item,
    output logic          res_valid,
    input  wire logic     res_ready,
    output bbc_out_t      res_item
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(MAX_LENGTH);
    localparam int PW = (IW > 12) ? IW : 12;

    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
    localparam logic [IW-1:0] IDX_MAX  = IW'(MAX_LENGTH - 1);

    logic [CW-1:0] count_reg,    count_next;
    logic [IW-1:0] idx_reg,      idx_next;
    bbc_status_t   err_reg,      err_next;
    logic [IW-1:0] err_idx_reg,  err_idx_next;
    bbc_kind_t     top_reg,      top_next;
    logic          top_ram_reg,  top_ram_next;
    logic          res_valid_reg, res_valid_next;
    bbc_out_t      res_item_reg, res_item_next;

    logic          accept;
    logic          active;
    bbc_class_t    cls;
    bbc_kind_t     top;
    logic          top_match;
    logic          push;
    logic          pop;
    logic          raise_ovf;
    logic          raise_mis;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [1:0]    ram_rdata;
    logic [CW-1:0] count_step;
    logic [PW-1:0] pos_ext;

    // Stack storage below the top entry
    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake
    assign sym_ready = !res_valid_reg || res_ready;
    assign accept    = sym_valid && sym_ready;
    assign active    = accept && (err_reg == ST_VALID);

    // Classify and compare against the top of stack
    assign cls       = bbc_classify(sym_item.symbol);
    assign top       = top_ram_reg ? bbc_kind_t'(ram_rdata) : top_reg;
    assign top_match = (count_reg != '0) && (top == cls.kind);

    assign push      = active && cls.is_open && (count_reg != CNT_FULL);
    assign raise_ovf = active && cls.is_open && (count_reg == CNT_FULL);
    assign pop       = active && cls.is_close && top_match;
    assign raise_mis = active && cls.is_close && !top_match;

    // Spill the old top on a push, fetch the next-lower entry on a pop
    assign ram_we    = push && (count_reg != '0);
    assign ram_waddr = AW'(count_reg - CW'(1));
    assign ram_re    = pop && (count_reg >= CW'(2));
    assign ram_raddr = AW'(count_reg - CW'(2));

    always_comb
    begin
        count_step   = count_reg;
        err_next     = err_reg;
        err_idx_next = err_idx_reg;
        top_next     = top_reg;
        top_ram_next = top_ram_reg;
        idx_next     = idx_reg;

        // Advance the stack
        if (push)
        begin
            count_step   = count_reg + CW'(1);
            top_next     = cls.kind;
            top_ram_next = 1'b0;
        end
        else if (pop)
        begin
            count_step   = count_reg - CW'(1);
            top_ram_next = ram_re;
        end

        // Latch the first error
        if (raise_ovf)
        begin
            err_next     = ST_OVERFLOW;
            err_idx_next = idx_reg;
        end
        else if (raise_mis)
        begin
            err_next     = ST_MISMATCH;
            err_idx_next = idx_reg;
        end

        // Form the verdict from the state after this character
        pos_ext = PW'(err_idx_next);
        res_item_next.status         = ST_VALID;
        res_item_next.error_position = '0;
        if (err_next != ST_VALID)
        begin
            res_item_next.status         = err_next;
            res_item_next.error_position = (pos_ext > PW'(POS_MAX)) ? POS_MAX
                                                                    : pos_ext[11:0];
        end
        else if (count_step != '0)
        begin
            res_item_next.status = ST_UNCLOSED;
        end

        // Output register: load on end of string, drop when taken
        res_valid_next = res_valid_reg && !res_ready;
        count_next     = count_step;

        if (accept)
        begin
            if (sym_item.end_of_string)
            begin
                res_valid_next = 1'b1;
                count_next     = '0;
                idx_next       = '0;
                err_next       = ST_VALID;
                err_idx_next   = '0;
                top_ram_next   = 1'b0;
            end
            else if (idx_reg != IDX_MAX)
            begin
                idx_next = idx_reg + IW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            err_reg       <= ST_VALID;
            err_idx_reg   <= '0;
            top_ram_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            err_reg       <= err_next;
            err_idx_reg   <= err_idx_next;
            top_ram_reg   <= top_ram_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (accept && sym_item.end_of_string)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

FILE: hdl/bbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, registered read port that holds its data between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/bbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bbc_checker
    import bbc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     sym_valid,
    input wire logic     sym_ready,
    input wire bbc_in_t  sym_item,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input wire bbc_out_t res_item
);

    // Hold a stalled verdict
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("verdict changed or dropped while stalled");

    // A clean or unclosed verdict carries no position
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.status == ST_VALID || res_item.status == ST_UNCLOSED)
        |-> res_item.error_position == 12'd0)
        else $error("position set on a verdict without error");

    // End of string yields a verdict in the next cycle
    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && sym_item.end_of_string |=> res_valid)
        else $error("no verdict after end of string");

    // A character inside a string yields no verdict
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && !sym_item.end_of_string && (!res_valid || res_ready)
        |=> !res_valid)
        else $error("verdict without end of string");

    // Input is open whenever the output register is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> sym_ready)
        else $error("input stalled with empty output");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (.*);

`default_nettype wire
